// ----- rtl/core/linear_regression_gradient_descent_core_assert.svh -----
// Assertion macros for the regression core
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_CORE_ASSERT_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define LRGD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
// next-cycle implication
`define LRGD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/lrgd_pkg.sv -----
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared constants and types of the gradient-descent regression core.
// ----------------------------------------------------------------------------
package lrgd_pkg;
    localparam int MAX_ROWS_DEF = 1024;
    localparam logic [15:0] STEP_RST = 16'd6554;
    localparam logic [15:0] ITER_RST = 16'd5000;
    localparam logic [0:0] REG_STEP = 1'b0;
    localparam logic [0:0] REG_ITER = 1'b1;

    typedef struct packed {
        logic signed [31:0] feature_one;
        logic signed [31:0] feature_two;
        logic signed [31:0] target_value;
        logic               last_sample;
    } row_t;

    typedef struct packed {
        logic [1:0]         coef_index;
        logic signed [31:0] coef_value;
        logic               final_coef;
        logic               rows_dropped;
    } coef_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction
endpackage

// ----- rtl/core/lrgd_if.sv -----
// ----------------------------------------------------------------------------
// lrgd_row_if / lrgd_coef_if
// Valid/ready channels carrying rows in and coefficients out.
// ----------------------------------------------------------------------------
interface lrgd_row_if;
    logic valid;
    logic ready;
    lrgd_pkg::row_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lrgd_coef_if;
    logic valid;
    logic ready;
    lrgd_pkg::coef_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/linear_regression_gradient_descent_core.sv -----
// Rows load one per cycle into two sample RAMs while the core is loading. The last row
// starts iteration_count passes (none if that count is 0 or no row was stored); a pass
// streams rows via the single RAM read port and a 3-stage multiply pipe, then serially
// divides and updates each coefficient; then 3 words leave through an output register.
// Reset clears row count, drop flag, run control and restores step 6554 / 5000 iterations.
// ----------------------------------------------------------------------------
// linear_regression_gradient_descent_core
// Batch gradient-descent linear regression over stored Q16.16 rows.
// ----------------------------------------------------------------------------
`include "linear_regression_gradient_descent_core_assert.svh"
module linear_regression_gradient_descent_core #(
    parameter int MAX_ROWS = lrgd_pkg::MAX_ROWS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    lrgd_row_if.sink     row_in,
    lrgd_coef_if.source  coef_out,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [15:0] step_reg, iter_reg;
    logic [2:0]  st_reg;
    logic [CW-1:0] cnt_reg;
    logic        ovf_reg;
    logic signed [31:0] th_reg [3];
    logic signed [63:0] gs_reg [3];
    logic [15:0] it_reg;
    logic [CW-1:0] rd_reg;
    logic [1:0]  k_reg;
    logic        div_go_reg;
    logic [3:0]  pv_reg;
    logic signed [63:0] dq_reg;
    logic        outv_reg;
    lrgd_pkg::coef_t out_reg;

    logic        accept, store;
    logic        issue, pass_end, emit, div_go_next;
    logic [63:0] f_rd;
    logic [31:0] t_rd;
    logic [AW-1:0] waddr;

    assign accept = row_in.valid && row_in.ready;
    assign row_in.ready = (st_reg == S_LOAD);
    assign store = accept && (cnt_reg < CW'(MAX_ROWS));
    assign waddr = cnt_reg[AW-1:0];

    // pass sequencing and output handshake
    assign issue       = (st_reg == S_PASS) && (rd_reg < cnt_reg);
    assign pass_end    = (rd_reg == cnt_reg) && (pv_reg == '0);
    assign emit        = (st_reg == S_OUT) && (!outv_reg || coef_out.ready);
    assign div_go_next = ((st_reg == S_PASS) && pass_end)
                         || ((st_reg == S_UPD) && (k_reg != 2'd2));

    lrgd_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_feat (
        .clk(clk), .we(store), .waddr(waddr),
        .wdata({row_in.data.feature_two, row_in.data.feature_one}),
        .raddr(rd_reg[AW-1:0]), .rdata(f_rd)
    );
    lrgd_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_targ (
        .clk(clk), .we(store), .waddr(waddr), .wdata(row_in.data.target_value),
        .raddr(rd_reg[AW-1:0]), .rdata(t_rd)
    );

    // pass pipeline: stage1 theta*x products, stage2 residual, stage3 x*res
    logic signed [63:0] p1_reg, p2_reg;
    logic signed [31:0] x1a_reg, x2a_reg, ta_reg, th0a_reg;
    logic signed [31:0] res_reg, x1b_reg, x2b_reg;
    logic signed [63:0] g1_reg, g2_reg;
    logic signed [31:0] res2_reg;
    logic signed [65:0] hsum;

    always_ff @(posedge clk)
    begin
        p1_reg   <= th_reg[1] * $signed(f_rd[31:0]);
        p2_reg   <= th_reg[2] * $signed(f_rd[63:32]);
        x1a_reg  <= f_rd[31:0];
        x2a_reg  <= f_rd[63:32];
        ta_reg   <= t_rd;
        th0a_reg <= th_reg[0];
        res_reg  <= lrgd_pkg::sat32(hsum);
        x1b_reg  <= x1a_reg;
        x2b_reg  <= x2a_reg;
        g1_reg   <= x1b_reg * res_reg;
        g2_reg   <= x2b_reg * res_reg;
        res2_reg <= res_reg;
    end
    assign hsum = 66'(th0a_reg) + 66'(p1_reg >>> 16) + 66'(p2_reg >>> 16) - 66'(ta_reg);

    // division of gradient sums by row count
    logic div_done;
    logic signed [63:0] div_q;
    lrgd_div #(.NW(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_go_reg),
        .dividend(gs_reg[k_reg]), .divisor(cnt_reg),
        .done(div_done), .quotient(div_q)
    );

    logic signed [63:0] dprod;
    logic signed [65:0] upd;
    assign dprod = dq_reg * $signed({1'b0, step_reg});
    assign upd = 66'(th_reg[k_reg]) - 66'(dprod >>> 16);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= lrgd_pkg::STEP_RST;
            iter_reg   <= lrgd_pkg::ITER_RST;
            st_reg     <= S_LOAD;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            pv_reg     <= '0;
            div_go_reg <= 1'b0;
            outv_reg   <= 1'b0;
            it_reg     <= '0;
            rd_reg     <= '0;
            k_reg      <= '0;
            dq_reg     <= '0;
            out_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                th_reg[i] <= '0;
                gs_reg[i] <= '0;
            end
        end
        else
        begin
            div_go_reg <= div_go_next;
            if (cfg_we)
            begin
                if (cfg_index == lrgd_pkg::REG_STEP)
                    step_reg <= cfg_data;
                else
                    iter_reg <= cfg_data;
            end
            outv_reg <= emit || (outv_reg && !coef_out.ready);
            pv_reg <= {pv_reg[2:0], issue};
            case (st_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (!store)
                            ovf_reg <= 1'b1;
                        if (store)
                            cnt_reg <= cnt_reg + CW'(1);
                        if (row_in.data.last_sample)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                th_reg[i] <= '0;
                                gs_reg[i] <= '0;
                            end
                            rd_reg <= '0;
                            it_reg <= '0;
                            k_reg  <= '0;
                            if (!store && cnt_reg == '0 || iter_reg == '0)
                                st_reg <= S_OUT;
                            else
                                st_reg <= S_PASS;
                        end
                    end
                end
                S_PASS:
                begin
                    if (issue)
                        rd_reg <= rd_reg + CW'(1);
                    if (pv_reg[3])
                    begin
                        gs_reg[0] <= gs_reg[0] + 64'(res2_reg);
                        gs_reg[1] <= gs_reg[1] + (g1_reg >>> 16);
                        gs_reg[2] <= gs_reg[2] + (g2_reg >>> 16);
                    end
                    if (pass_end)
                    begin
                        st_reg <= S_DIV;
                        k_reg  <= '0;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        dq_reg <= div_q;
                        st_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    th_reg[k_reg] <= lrgd_pkg::sat32(upd);
                    if (k_reg == 2'd2)
                    begin
                        for (int i = 0; i < 3; i++)
                            gs_reg[i] <= '0;
                        rd_reg <= '0;
                        k_reg  <= '0;
                        it_reg <= it_reg + 16'd1;
                        if (it_reg + 16'd1 == iter_reg)
                            st_reg <= S_OUT;
                        else
                            st_reg <= S_PASS;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 2'd1;
                        st_reg <= S_DIV;
                    end
                end
                S_OUT:
                begin
                    if (emit)
                    begin
                        out_reg.coef_index   <= k_reg;
                        out_reg.coef_value   <= th_reg[k_reg];
                        out_reg.final_coef   <= (k_reg == 2'd2);
                        out_reg.rows_dropped <= ovf_reg;
                        k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                        if (k_reg == 2'd2)
                        begin
                            cnt_reg <= '0;
                            ovf_reg <= 1'b0;
                            st_reg  <= S_LOAD;
                        end
                    end
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end

    assign coef_out.valid = outv_reg;
    assign coef_out.data  = out_reg;

    `LRGD_ASSERT_IMP(a_no_accept_busy, st_reg != S_LOAD, !row_in.ready)
    `LRGD_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= CW'(MAX_ROWS))
    `LRGD_ASSERT_NXT(a_out_hold, outv_reg && !coef_out.ready, outv_reg && $stable(out_reg))
endmodule

// ----- rtl/core/lrgd_ram.sv -----
// ----------------------------------------------------------------------------
// lrgd_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/lrgd_div.sv -----
// ----------------------------------------------------------------------------
// lrgd_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module lrgd_div #(
    parameter int NW = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  dividend,
    input  logic [NW-1:0]       divisor,
    output logic                done,
    output logic signed [63:0]  quotient
);
    logic [63:0] quo_reg, quo_next;
    logic [NW:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [NW:0] trial;

    // shift-subtract step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[NW-1:0], quo_reg[63]};
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[63];
            quo_next  = dividend[63] ? 64'(-dividend) : 64'(dividend);
            rem_next  = '0;
            cnt_next  = 7'd0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end
    assign quotient = neg_reg ? -$signed(quo_next) : $signed(quo_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end
endmodule
